>>> rtl/slrs_pkg.sv
// Shared types and constants for the serial line reset and strap sequencer.
`timescale 1ns / 1ps

package slrs_pkg;

  localparam int unsigned SETTLE_WIDTH_DEF = 16;
  localparam int unsigned STRAP_WIDTH      = 8;
  localparam int unsigned CFG_SETTLE_WIDTH = 16;
  localparam int unsigned CFG_DATA_WIDTH   = 16;
  localparam int unsigned CFG_INDEX_WIDTH  = 1;

  localparam logic [STRAP_WIDTH-1:0]      STRAP_HOLD_RESET  = 8'd2;
  localparam logic [CFG_SETTLE_WIDTH-1:0] LINE_SETTLE_RESET = 16'd25;

  // holder mask bits
  localparam logic [1:0] HOLD_SW     = 2'b01;
  localparam logic [1:0] HOLD_SERIAL = 2'b10;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_LINE   = 2'd1,
    OP_ENABLE = 2'd2,
    OP_RESET  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    PEND_NONE         = 2'd0,
    PEND_NORMAL       = 2'd1,
    PEND_BOOT         = 2'd2,
    PEND_NORMAL_AFTER = 2'd3
  } pend_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_STRAP_HOLD  = 1'd0,
    REG_LINE_SETTLE = 1'd1
  } reg_index_t;

  typedef struct packed {
    logic [STRAP_WIDTH-1:0]      strap_hold_ticks;
    logic [CFG_SETTLE_WIDTH-1:0] line_settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       dtr_level;
    logic       rts_level;
    logic       enable_level;
    logic       want_bootloader;
  } item_t;

  typedef struct packed {
    logic       enable_held_low;
    logic       straps_driven;
    logic       bootloader_strap;
    logic [1:0] hold_sources;
  } result_t;

endpackage

>>> rtl/slrs_if.sv
// Handshake channel interfaces: event items, results and register writes.
`timescale 1ns / 1ps

interface slrs_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       dtr_level;
  logic       rts_level;
  logic       enable_level;
  logic       want_bootloader;

  modport source (output valid, opcode, dtr_level, rts_level, enable_level,
                  want_bootloader, input ready);
  modport sink   (input valid, opcode, dtr_level, rts_level, enable_level,
                  want_bootloader, output ready);
endinterface

interface slrs_result_if;
  logic       valid;
  logic       ready;
  logic       enable_held_low;
  logic       straps_driven;
  logic       bootloader_strap;
  logic [1:0] hold_sources;

  modport source (output valid, enable_held_low, straps_driven, bootloader_strap,
                  hold_sources, input ready);
  modport sink   (input valid, enable_held_low, straps_driven, bootloader_strap,
                  hold_sources, output ready);
endinterface

interface slrs_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [slrs_pkg::CFG_INDEX_WIDTH-1:0]  index;
  logic [slrs_pkg::CFG_DATA_WIDTH-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/slrs_cfg_regs.sv
// Configuration register file: strap hold and line settle delays.
`timescale 1ns / 1ps

module slrs_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  slrs_cfg_if.sink         cfg,
  output slrs_pkg::cfg_t   regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.strap_hold_ticks  <= slrs_pkg::STRAP_HOLD_RESET;
      regs.line_settle_ticks <= slrs_pkg::LINE_SETTLE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (slrs_pkg::reg_index_t'(cfg.index))
        slrs_pkg::REG_STRAP_HOLD:
          regs.strap_hold_ticks <= cfg.data[slrs_pkg::STRAP_WIDTH-1:0];
        slrs_pkg::REG_LINE_SETTLE:
          regs.line_settle_ticks <= cfg.data[slrs_pkg::CFG_SETTLE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/slrs_core.sv
// Sequencer state and the single-pass next-state logic for one event.
`timescale 1ns / 1ps

module slrs_core #(
  parameter int unsigned SETTLE_WIDTH = slrs_pkg::SETTLE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  slrs_pkg::item_t   item,
  input  slrs_pkg::cfg_t    regs,
  output slrs_pkg::result_t res
);

  logic [1:0]                       mask;
  slrs_pkg::pend_t                  pend;
  logic [slrs_pkg::STRAP_WIDTH-1:0] strap_cnt;
  logic [SETTLE_WIDTH-1:0]          settle_cnt;
  logic                             saved_dtr;
  logic                             saved_rts;
  logic                             prev_en;
  logic                             straps_drv;
  logic                             straps_boot;

  logic [1:0]                       mask_next;
  slrs_pkg::pend_t                  pend_next;
  logic [slrs_pkg::STRAP_WIDTH-1:0] strap_cnt_next;
  logic [SETTLE_WIDTH-1:0]          settle_cnt_next;
  logic                             saved_dtr_next;
  logic                             saved_rts_next;
  logic                             prev_en_next;
  logic                             straps_drv_next;
  logic                             straps_boot_next;

  logic [slrs_pkg::STRAP_WIDTH-1:0] strap_reload;
  logic [SETTLE_WIDTH-1:0]          settle_cfg;
  logic [SETTLE_WIDTH-1:0]          settle_reload;
  logic                             strap_due;
  logic                             settle_due;

  // zero delay counts as one tick
  assign strap_reload  = (regs.strap_hold_ticks == '0) ?
                         slrs_pkg::STRAP_WIDTH'(1) : regs.strap_hold_ticks;
  assign settle_cfg    = SETTLE_WIDTH'(regs.line_settle_ticks);
  assign settle_reload = (settle_cfg == '0) ? SETTLE_WIDTH'(1) : settle_cfg;

  always_comb begin
    mask_next        = mask;
    pend_next        = pend;
    strap_cnt_next   = strap_cnt;
    settle_cnt_next  = settle_cnt;
    saved_dtr_next   = saved_dtr;
    saved_rts_next   = saved_rts;
    prev_en_next     = prev_en;
    straps_drv_next  = straps_drv;
    straps_boot_next = straps_boot;
    strap_due        = 1'b0;
    settle_due       = 1'b0;

    unique case (slrs_pkg::opcode_t'(item.opcode))
      slrs_pkg::OP_TICK: begin
        if (strap_cnt != '0) begin
          strap_cnt_next = strap_cnt - slrs_pkg::STRAP_WIDTH'(1);
          strap_due      = (strap_cnt == slrs_pkg::STRAP_WIDTH'(1));
        end
        if (settle_cnt != '0) begin
          settle_cnt_next = settle_cnt - SETTLE_WIDTH'(1);
          settle_due      = (settle_cnt == SETTLE_WIDTH'(1));
        end
        // pending reset: software holder pulls low and lets go at once
        if (pend != slrs_pkg::PEND_NONE) begin
          mask_next = mask_next & ~slrs_pkg::HOLD_SW;
          if (mask_next == '0) begin
            straps_drv_next  = 1'b1;
            straps_boot_next = (pend == slrs_pkg::PEND_BOOT);
            strap_cnt_next   = strap_reload;
            strap_due        = 1'b0;
          end
        end
        pend_next = slrs_pkg::PEND_NONE;
        if (strap_due) begin
          straps_drv_next  = 1'b0;
          straps_boot_next = 1'b0;
        end
        if (settle_due) begin
          if (saved_rts && !saved_dtr) begin
            mask_next = mask_next | slrs_pkg::HOLD_SERIAL;
          end else begin
            mask_next = mask_next & ~slrs_pkg::HOLD_SERIAL;
            if (mask_next == '0) begin
              straps_drv_next  = 1'b1;
              straps_boot_next = saved_dtr && !saved_rts;
              strap_cnt_next   = strap_reload;
            end
          end
        end
      end
      slrs_pkg::OP_LINE: begin
        saved_dtr_next  = item.dtr_level;
        saved_rts_next  = item.rts_level;
        settle_cnt_next = settle_reload;
      end
      slrs_pkg::OP_ENABLE: begin
        if (item.enable_level && !prev_en && (mask == '0)) begin
          pend_next = (saved_dtr && !saved_rts) ? slrs_pkg::PEND_BOOT
                                                : slrs_pkg::PEND_NORMAL;
        end
        prev_en_next = item.enable_level;
      end
      slrs_pkg::OP_RESET: begin
        pend_next = item.want_bootloader ? slrs_pkg::PEND_BOOT : slrs_pkg::PEND_NORMAL;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask        <= '0;
      pend        <= slrs_pkg::PEND_NORMAL;
      strap_cnt   <= '0;
      settle_cnt  <= '0;
      saved_dtr   <= 1'b0;
      saved_rts   <= 1'b0;
      prev_en     <= 1'b1;
      straps_drv  <= 1'b0;
      straps_boot <= 1'b0;
    end else if (fire) begin
      mask        <= mask_next;
      pend        <= pend_next;
      strap_cnt   <= strap_cnt_next;
      settle_cnt  <= settle_cnt_next;
      saved_dtr   <= saved_dtr_next;
      saved_rts   <= saved_rts_next;
      prev_en     <= prev_en_next;
      straps_drv  <= straps_drv_next;
      straps_boot <= straps_boot_next;
    end
  end

  assign res.enable_held_low  = |mask_next;
  assign res.straps_driven    = straps_drv_next;
  assign res.bootloader_strap = straps_boot_next;
  assign res.hold_sources     = mask_next;

endmodule

>>> rtl/serial_line_reset_strap_sequencer.sv
// Serial line reset and boot strap sequencer: top level with event and result registers.
//
// Channels: item (sink) carries one event per transfer: tick, DTR/RTS change,
// enable level change or reset request. result (source) returns one transfer per
// event with the enable hold state, strap drive state and holder mask as they
// stand after that event. cfg (sink) writes the strap hold delay (index 0) and the
// line settle delay (index 1); it is always ready and must only be used while idle.
// Timing: an event is held in the input register and its result is loaded into the
// output register once that register is free or being emptied; result.valid then
// rises and stays high until the result is taken.
// Throughput: one event per cycle while the result side does not stall; the state
// update is a single pass of logic between the input register and the result register.
// Reset: a normal reset is pending, enable released, straps released, both delays
// back to 2 and 25 ticks. When the result side stalls, the input register fills
// and item.ready drops only once both registers hold an unsent event.
`timescale 1ns / 1ps

module serial_line_reset_strap_sequencer #(
  parameter int unsigned SETTLE_WIDTH = slrs_pkg::SETTLE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  slrs_item_if.sink     item,
  slrs_result_if.source result,
  slrs_cfg_if.sink      cfg
);

  slrs_pkg::cfg_t    regs;
  slrs_pkg::item_t   item_q;
  logic              item_vld;
  slrs_pkg::result_t res_next;
  slrs_pkg::result_t res_q;
  logic              res_vld;
  logic              out_free;
  logic              adv;

  assign out_free   = !res_vld || result.ready;
  assign adv        = item_vld && out_free;
  assign item.ready = !item_vld || out_free;

  slrs_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  slrs_core #(
    .SETTLE_WIDTH (SETTLE_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (adv),
    .item (item_q),
    .regs (regs),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (item.valid && item.ready) begin
      item_vld <= 1'b1;
    end else if (adv) begin
      item_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      item_q.opcode          <= item.opcode;
      item_q.dtr_level       <= item.dtr_level;
      item_q.rts_level       <= item.rts_level;
      item_q.enable_level    <= item.enable_level;
      item_q.want_bootloader <= item.want_bootloader;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (adv) begin
      res_vld <= 1'b1;
    end else if (result.ready) begin
      res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_q <= res_next;
    end
  end

  assign result.valid            = res_vld;
  assign result.enable_held_low  = res_q.enable_held_low;
  assign result.straps_driven    = res_q.straps_driven;
  assign result.bootloader_strap = res_q.bootloader_strap;
  assign result.hold_sources     = res_q.hold_sources;

endmodule
